// ===== sv/cdpc_pkg.sv =====
// cdpc_pkg: shared constants, CORDIC arctangent table and register map for the
// cascaded drive power controller. No dependencies.
package cdpc_pkg;

  typedef enum logic [2:0] {
    REG_POWER_LIMIT  = 3'd0,
    REG_SPEED_GAIN   = 3'd1,
    REG_FF_GAIN      = 3'd2,
    REG_MAX_SPEED    = 3'd3,
    REG_PROFILE_RATE = 3'd4
  } cfg_reg_t;

  localparam logic [29:0] CORDIC_INV_GAIN = 30'd652032874;
  localparam logic [30:0] Q30_ONE         = 31'h4000_0000;
  localparam logic [29:0] LN2_Q30         = 30'd744261118;
  localparam logic [21:0] T_SAT           = 22'd2097152;
  // floor(2^46 / LN2_Q30): n estimate is exact or one short
  localparam logic [16:0] RECIP_LN2       = 17'd94548;

  localparam logic [31:0] ATAN_TAB [0:31] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

endpackage

// ===== sv/cdpc_vec_cordic.sv =====
// cdpc_vec_cordic: pipelined vectoring CORDIC, one stage per step, giving the
// raw magnitude and 32-bit binary angle of (x, y). Uses cdpc_pkg.
module cdpc_vec_cordic #(
  parameter int STEPS = 16,
  parameter int TW    = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [32:0] in_x,
  input  logic signed [32:0] in_y,
  input  logic [TW-1:0]      in_tag,
  output logic               out_valid,
  output logic [35:0]        out_mag,
  output logic [31:0]        out_ang,
  output logic [TW-1:0]      out_tag
);

  localparam int XW = 38;

  logic                 v_r   [0:STEPS];
  logic signed [XW-1:0] x_r   [0:STEPS];
  logic signed [XW-1:0] y_r   [0:STEPS];
  logic [31:0]          z_r   [0:STEPS];
  logic [TW-1:0]        tag_r [0:STEPS];

  logic signed [XW-1:0] x_ext, y_ext;
  assign x_ext = {{(XW-33){in_x[32]}}, in_x};
  assign y_ext = {{(XW-33){in_y[32]}}, in_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  // fold the left half plane over by half a turn
  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    if (in_x < 0) begin
      x_r[0] <= -x_ext;
      y_r[0] <= -y_ext;
      z_r[0] <= 32'h8000_0000;
    end else begin
      x_r[0] <= x_ext;
      y_r[0] <= y_ext;
      z_r[0] <= 32'h0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [XW-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      tag_r[i+1] <= tag_r[i];
      if (y_r[i] > 0) begin
        x_r[i+1] <= x_r[i] + ys;
        y_r[i+1] <= y_r[i] - xs;
        z_r[i+1] <= z_r[i] + cdpc_pkg::ATAN_TAB[i];
      end else begin
        x_r[i+1] <= x_r[i] - ys;
        y_r[i+1] <= y_r[i] + xs;
        z_r[i+1] <= z_r[i] - cdpc_pkg::ATAN_TAB[i];
      end
    end
  end

  assign out_valid = v_r[STEPS];
  assign out_mag   = x_r[STEPS][35:0];
  assign out_ang   = z_r[STEPS];
  assign out_tag   = tag_r[STEPS];

endmodule

// ===== sv/cdpc_rot_cordic.sv =====
// cdpc_rot_cordic: pipelined rotation CORDIC giving cos and sin (Q4.30) of a
// 16-bit binary angle; quarter turns come out exact. Uses cdpc_pkg.
module cdpc_rot_cordic #(
  parameter int STEPS = 16,
  parameter int TW    = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [15:0]        in_angle,
  input  logic [TW-1:0]      in_tag,
  output logic               out_valid,
  output logic signed [33:0] out_cos,
  output logic signed [33:0] out_sin,
  output logic [TW-1:0]      out_tag
);

  localparam int RW = 34;

  logic                 v_r   [0:STEPS];
  logic signed [RW-1:0] x_r   [0:STEPS];
  logic signed [RW-1:0] y_r   [0:STEPS];
  logic signed [RW-1:0] z_r   [0:STEPS];
  logic [1:0]           q_r   [0:STEPS];
  logic                 f_r   [0:STEPS];
  logic [TW-1:0]        tag_r [0:STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    q_r[0]   <= in_angle[15:14];
    f_r[0]   <= (in_angle[13:0] == 14'd0);
    x_r[0]   <= $signed({4'b0, cdpc_pkg::CORDIC_INV_GAIN});
    y_r[0]   <= '0;
    z_r[0]   <= $signed({4'b0, in_angle[13:0], 16'b0});
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [RW-1:0] xs, ys, at;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    assign at = $signed({2'b0, cdpc_pkg::ATAN_TAB[i]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      tag_r[i+1] <= tag_r[i];
      q_r[i+1]   <= q_r[i];
      f_r[i+1]   <= f_r[i];
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - ys;
        y_r[i+1] <= y_r[i] + xs;
        z_r[i+1] <= z_r[i] - at;
      end else begin
        x_r[i+1] <= x_r[i] + ys;
        y_r[i+1] <= y_r[i] - xs;
        z_r[i+1] <= z_r[i] + at;
      end
    end
  end

  logic signed [RW-1:0] xf, yf;
  assign xf = f_r[STEPS] ? $signed({3'b0, cdpc_pkg::Q30_ONE}) : x_r[STEPS];
  assign yf = f_r[STEPS] ? '0 : y_r[STEPS];

  // quadrant fold-out
  always_comb begin
    case (q_r[STEPS])
      2'd0: begin
        out_cos = xf;
        out_sin = yf;
      end
      2'd1: begin
        out_cos = -yf;
        out_sin = xf;
      end
      2'd2: begin
        out_cos = -xf;
        out_sin = -yf;
      end
      default: begin
        out_cos = yf;
        out_sin = -xf;
      end
    endcase
  end

  assign out_valid = v_r[STEPS];
  assign out_tag   = tag_r[STEPS];

endmodule

// ===== sv/cdpc_exp.sv =====
// cdpc_exp: exp(-r) for 0 <= r < ln2 in Q30, a 12-term Horner series with
// three register stages per term. Uses cdpc_pkg.
module cdpc_exp #(
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [29:0]   in_r,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [30:0]   out_e,
  output logic [TW-1:0] out_tag
);

  localparam int TERMS = 12;

  logic          v_r [1:TERMS];
  logic [30:0]   e_r [1:TERMS];
  logic [29:0]   r_r [1:TERMS];
  logic [TW-1:0] t_r [1:TERMS];

  for (genvar s = 0; s < TERMS; s++) begin : g_term
    localparam int K = TERMS - s;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);

    logic          v_in;
    logic [30:0]   e_in;
    logic [29:0]   r_in;
    logic [TW-1:0] t_in;

    if (s == 0) begin : g_first
      assign v_in = in_valid;
      assign e_in = cdpc_pkg::Q30_ONE;
      assign r_in = in_r;
      assign t_in = in_tag;
    end else begin : g_next
      assign v_in = v_r[s];
      assign e_in = e_r[s];
      assign r_in = r_r[s];
      assign t_in = t_r[s];
    end

    logic          va_r, vb_r;
    logic [30:0]   pa_r, pb_r, qb_r;
    logic [29:0]   ra_r, rb_r;
    logic [TW-1:0] ta_r, tb_r;
    logic [60:0]   prod;
    logic [63:0]   qm;
    logic [30:0]   qk, rem, q;

    assign prod = r_in * e_in;
    assign qm   = pa_r * RECIP;
    assign qk   = 31'(qb_r * 31'(K));
    assign rem  = pb_r - qk;
    // reciprocal estimate is at most one short
    assign q    = (rem >= 31'(K)) ? qb_r + 31'd1 : qb_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r     <= 1'b0;
        vb_r     <= 1'b0;
        v_r[s+1] <= 1'b0;
      end else begin
        va_r     <= v_in;
        vb_r     <= va_r;
        v_r[s+1] <= vb_r;
      end
    end

    always_ff @(posedge clk) begin
      pa_r     <= prod[60:30];
      ra_r     <= r_in;
      ta_r     <= t_in;
      pb_r     <= pa_r;
      qb_r     <= qm[62:32];
      rb_r     <= ra_r;
      tb_r     <= ta_r;
      e_r[s+1] <= cdpc_pkg::Q30_ONE - q;
      r_r[s+1] <= rb_r;
      t_r[s+1] <= tb_r;
    end
  end

  assign out_valid = v_r[TERMS];
  assign out_e     = e_r[TERMS];
  assign out_tag   = t_r[TERMS];

endmodule

// ===== sv/cascaded_drive_power_controller.sv =====
// cascaded_drive_power_controller: top level, APB register file and the
// arithmetic stages between the CORDIC and exp pipelines.
// Depends on cdpc_pkg, cdpc_vec_cordic, cdpc_rot_cordic, cdpc_exp.
//
// Usage: drive the pose, velocity, goal and stop-early fields with start high
// for one cycle per item; busy is never raised, so an item may be given every
// cycle. Each item gives one result: out_valid is high for exactly one cycle
// with out_left_power and out_right_power (equal) and the receiver must take
// it then, there is no hold-off.
// The path runs through an input register, the vectoring CORDIC (bearing,
// distance), the rotation CORDIC on the bearing error, the division by ln2,
// a 36-stage Horner exp and the gain and clamp stages. Throughput is one
// item per cycle.
// Gains and limits are written over the APB port, register i at byte 4*i;
// they are to be changed only while no item is in flight.
// Reset (rst_n low, synchronous) clears the configuration registers and the
// valid chain to zero, emptying the pipeline; items in flight are dropped.
module cascaded_drive_power_controller #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [15:0] in_heading,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_goal_x,
  input  logic signed [31:0] in_goal_y,
  input  logic signed [31:0] in_stop_early,
  output logic        out_valid,
  output logic signed [31:0] out_left_power,
  output logic signed [31:0] out_right_power,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------- register file ----------------
  logic [30:0] power_limit_r, speed_gain_r, ff_gain_r, max_speed_r, profile_rate_r;
  logic        wr_en;
  cdpc_pkg::cfg_reg_t reg_sel;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = cdpc_pkg::cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_limit_r  <= '0;
      speed_gain_r   <= '0;
      ff_gain_r      <= '0;
      max_speed_r    <= '0;
      profile_rate_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        cdpc_pkg::REG_POWER_LIMIT:  power_limit_r  <= pwdata[30:0];
        cdpc_pkg::REG_SPEED_GAIN:   speed_gain_r   <= pwdata[30:0];
        cdpc_pkg::REG_FF_GAIN:      ff_gain_r      <= pwdata[30:0];
        cdpc_pkg::REG_MAX_SPEED:    max_speed_r    <= pwdata[30:0];
        cdpc_pkg::REG_PROFILE_RATE: profile_rate_r <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      cdpc_pkg::REG_POWER_LIMIT:  prdata = {1'b0, power_limit_r};
      cdpc_pkg::REG_SPEED_GAIN:   prdata = {1'b0, speed_gain_r};
      cdpc_pkg::REG_FF_GAIN:      prdata = {1'b0, ff_gain_r};
      cdpc_pkg::REG_MAX_SPEED:    prdata = {1'b0, max_speed_r};
      cdpc_pkg::REG_PROFILE_RATE: prdata = {1'b0, profile_rate_r};
      default:                    prdata = '0;
    endcase
  end

  // ---------------- S0: input register ----------------
  logic               s0_v_r, s0_zero_r;
  logic signed [32:0] s0_dx_r, s0_dy_r, s0_dx_nxt, s0_dy_nxt;
  logic [15:0]        s0_head_r;
  logic signed [31:0] s0_vx_r, s0_vy_r, s0_stop_r;

  assign s0_dx_nxt = 33'(in_goal_x) - 33'(in_pos_x);
  assign s0_dy_nxt = 33'(in_goal_y) - 33'(in_pos_y);

  always_ff @(posedge clk) begin
    s0_dx_r   <= s0_dx_nxt;
    s0_dy_r   <= s0_dy_nxt;
    s0_zero_r <= (s0_dx_nxt == '0) && (s0_dy_nxt == '0);
    s0_head_r <= in_heading;
    s0_vx_r   <= in_vel_x;
    s0_vy_r   <= in_vel_y;
    s0_stop_r <= in_stop_early;
  end

  // ---------------- bearing / distance and heading CORDICs ----------------
  localparam int VT = 49;
  localparam int HT = 64;

  logic               c1_v, h_v;
  logic [35:0]        c1_mag;
  logic [31:0]        c1_ang;
  logic [VT-1:0]      c1_tag;
  logic signed [33:0] h_cos, h_sin;
  logic [HT-1:0]      h_tag;

  cdpc_vec_cordic #(.STEPS(CORDIC_STEPS), .TW(VT)) u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_v_r),
    .in_x      (s0_dx_r),
    .in_y      (s0_dy_r),
    .in_tag    ({s0_zero_r, s0_head_r, s0_stop_r}),
    .out_valid (c1_v),
    .out_mag   (c1_mag),
    .out_ang   (c1_ang),
    .out_tag   (c1_tag)
  );

  cdpc_rot_cordic #(.STEPS(CORDIC_STEPS), .TW(HT)) u_rot_head (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_v_r),
    .in_angle  (s0_head_r),
    .in_tag    ({s0_vx_r, s0_vy_r}),
    .out_valid (h_v),
    .out_cos   (h_cos),
    .out_sin   (h_sin),
    .out_tag   (h_tag)
  );

  // ---------------- S1: bearing error, magnitude and velocity products ---------
  logic               c1_zero;
  logic [15:0]        c1_head, c1_bear;
  logic signed [31:0] c1_stop, h_vx, h_vy;
  logic [31:0]        c1_ang_eff, c1_ang_rnd;

  assign {c1_zero, c1_head, c1_stop} = c1_tag;
  assign {h_vx, h_vy}                = h_tag;
  // target on the robot: bearing forced to zero
  assign c1_ang_eff = c1_zero ? 32'h0 : c1_ang;
  assign c1_ang_rnd = c1_ang_eff + 32'h0000_8000;
  assign c1_bear    = c1_ang_rnd[31:16];

  logic               s1_v_r;
  logic [47:0]        s1_mph_r, s1_mpl_r;
  logic [15:0]        s1_ea_r;
  logic signed [65:0] s1_pvx_r, s1_pvy_r, s1_pvx_nxt, s1_pvy_nxt;
  logic signed [31:0] s1_stop_r;

  assign s1_pvx_nxt = h_vx * h_cos;
  assign s1_pvy_nxt = h_vy * h_sin;

  always_ff @(posedge clk) begin
    s1_mph_r  <= c1_mag[35:18] * cdpc_pkg::CORDIC_INV_GAIN;
    s1_mpl_r  <= c1_mag[17:0] * cdpc_pkg::CORDIC_INV_GAIN;
    s1_ea_r   <= c1_head - c1_bear;
    s1_pvx_r  <= s1_pvx_nxt;
    s1_pvy_r  <= s1_pvy_nxt;
    s1_stop_r <= c1_stop;
  end

  // ---------------- S2: distance and longitudinal speed ----------------
  logic [66:0]        s2_dsum;
  logic signed [66:0] s2_vsum;
  logic               s2_v_r;
  logic [35:0]        s2_dist_r;
  logic signed [34:0] s2_vel_r;
  logic [15:0]        s2_ea_r;
  logic signed [31:0] s2_stop_r;

  assign s2_dsum = {1'b0, s1_mph_r, 18'b0} + 67'(s1_mpl_r) + 67'(64'd1 << 29);
  assign s2_vsum = 67'(s1_pvx_r) + 67'(s1_pvy_r);

  always_ff @(posedge clk) begin
    s2_dist_r <= s2_dsum[65:30];
    s2_vel_r  <= s2_vsum[64:30];
    s2_ea_r   <= s1_ea_r;
    s2_stop_r <= s1_stop_r;
  end

  // ---------------- bearing error CORDIC ----------------
  localparam int ET = 36 + 35 + 32;

  logic               e_v;
  logic signed [33:0] e_cos;
  logic [ET-1:0]      e_tag;

  cdpc_rot_cordic #(.STEPS(CORDIC_STEPS), .TW(ET)) u_rot_err (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_v_r),
    .in_angle  (s2_ea_r),
    .in_tag    ({s2_dist_r, s2_vel_r, s2_stop_r}),
    .out_valid (e_v),
    .out_cos   (e_cos),
    .out_sin   (),
    .out_tag   (e_tag)
  );

  logic [35:0]        e_dist;
  logic signed [34:0] e_vel;
  logic signed [31:0] e_stop;
  assign {e_dist, e_vel, e_stop} = e_tag;

  // ---------------- S3: cos * distance partial products ----------------
  logic               s3_v_r, s3_cpos_r, s3_cneg_r;
  logic signed [52:0] s3_pch_r, s3_pcl_r, s3_pch_nxt, s3_pcl_nxt;
  logic signed [34:0] s3_vel_r;
  logic signed [31:0] s3_stop_r;

  assign s3_pch_nxt = e_cos * $signed({1'b0, e_dist[35:18]});
  assign s3_pcl_nxt = e_cos * $signed({1'b0, e_dist[17:0]});

  always_ff @(posedge clk) begin
    s3_pch_r  <= s3_pch_nxt;
    s3_pcl_r  <= s3_pcl_nxt;
    s3_cpos_r <= (e_cos > 0);
    s3_cneg_r <= (e_cos < 0);
    s3_vel_r  <= e_vel;
    s3_stop_r <= e_stop;
  end

  // ---------------- S4: longitudinal error ----------------
  logic signed [71:0] s4_cprod;
  logic signed [36:0] s4_err0;
  logic signed [37:0] s4_err_nxt;
  logic               s4_v_r;
  logic signed [37:0] s4_err_r;
  logic signed [34:0] s4_vel_r;

  assign s4_cprod = (72'(s3_pch_r) <<< 18) + 72'(s3_pcl_r);
  assign s4_err0  = s4_cprod[66:30];

  always_comb begin
    if (s3_cpos_r) begin
      s4_err_nxt = 38'(s4_err0) - 38'(s3_stop_r);
    end else if (s3_cneg_r) begin
      s4_err_nxt = 38'(s4_err0) + 38'(s3_stop_r);
    end else begin
      s4_err_nxt = 38'(s4_err0);
    end
  end

  always_ff @(posedge clk) begin
    s4_err_r <= s4_err_nxt;
    s4_vel_r <= s3_vel_r;
  end

  // ---------------- S5: profile_rate * |err| partial products ----------------
  logic [37:0]        s5_abs;
  logic               s5_v_r, s5_neg_r, s5_nz_r;
  logic [35:0]        s5_hi_r;
  logic [46:0]        s5_ph_r, s5_pl_r;
  logic signed [34:0] s5_vel_r;

  assign s5_abs = s4_err_r[37] ? 38'(-s4_err_r) : 38'(s4_err_r);

  always_ff @(posedge clk) begin
    s5_hi_r  <= profile_rate_r * s5_abs[36:32];
    s5_ph_r  <= profile_rate_r * s5_abs[31:16];
    s5_pl_r  <= profile_rate_r * s5_abs[15:0];
    s5_neg_r <= s4_err_r[37];
    s5_nz_r  <= (s4_err_r != '0);
    s5_vel_r <= s4_vel_r;
  end

  // ---------------- S6: exponent argument, saturated ----------------
  logic [47:0]        s6_tt;
  logic [21:0]        s6_t_nxt;
  logic               s6_v_r, s6_neg_r, s6_nz_r;
  logic [21:0]        s6_t_r;
  logic signed [34:0] s6_vel_r;

  assign s6_tt = {27'b0, s5_hi_r[4:0], 16'b0} + {1'b0, s5_ph_r} + 48'(s5_pl_r >> 16);

  always_comb begin
    if (s5_hi_r >= 36'd32) begin
      s6_t_nxt = cdpc_pkg::T_SAT;
    end else if (s6_tt > 48'(cdpc_pkg::T_SAT)) begin
      s6_t_nxt = cdpc_pkg::T_SAT;
    end else begin
      s6_t_nxt = s6_tt[21:0];
    end
  end

  always_ff @(posedge clk) begin
    s6_t_r   <= s6_t_nxt;
    s6_neg_r <= s5_neg_r;
    s6_nz_r  <= s5_nz_r;
    s6_vel_r <= s5_vel_r;
  end

  // ---------------- S7..S9: split argument into n*ln2 + r ----------------
  logic               s7_v_r, s7_neg_r, s7_nz_r;
  logic [21:0]        s7_t_r;
  logic [38:0]        s7_tm_r;
  logic signed [34:0] s7_vel_r;

  always_ff @(posedge clk) begin
    s7_t_r   <= s6_t_r;
    s7_tm_r  <= s6_t_r * cdpc_pkg::RECIP_LN2;
    s7_neg_r <= s6_neg_r;
    s7_nz_r  <= s6_nz_r;
    s7_vel_r <= s6_vel_r;
  end

  logic [5:0]         s8_q_nxt;
  logic [35:0]        s8_ql, s8_big;
  logic               s8_v_r, s8_neg_r, s8_nz_r;
  logic [5:0]         s8_q_r;
  logic [30:0]        s8_rem_r;
  logic signed [34:0] s8_vel_r;

  assign s8_q_nxt = s7_tm_r[37:32];
  assign s8_ql    = s8_q_nxt * cdpc_pkg::LN2_Q30;
  assign s8_big   = {s7_t_r, 14'b0};

  always_ff @(posedge clk) begin
    s8_q_r   <= s8_q_nxt;
    s8_rem_r <= 31'(s8_big - s8_ql);
    s8_neg_r <= s7_neg_r;
    s8_nz_r  <= s7_nz_r;
    s8_vel_r <= s7_vel_r;
  end

  logic               s9_v_r, s9_neg_r, s9_nz_r;
  logic [5:0]         s9_n_r;
  logic [29:0]        s9_r_r;
  logic signed [34:0] s9_vel_r;

  always_ff @(posedge clk) begin
    if (s8_rem_r >= {1'b0, cdpc_pkg::LN2_Q30}) begin
      s9_n_r <= s8_q_r + 6'd1;
      s9_r_r <= 30'(s8_rem_r - {1'b0, cdpc_pkg::LN2_Q30});
    end else begin
      s9_n_r <= s8_q_r;
      s9_r_r <= s8_rem_r[29:0];
    end
    s9_neg_r <= s8_neg_r;
    s9_nz_r  <= s8_nz_r;
    s9_vel_r <= s8_vel_r;
  end

  // ---------------- exp(-r) ----------------
  localparam int XT = 6 + 2 + 35;

  logic          x_v;
  logic [30:0]   x_e;
  logic [XT-1:0] x_tag;

  cdpc_exp #(.TW(XT)) u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s9_v_r),
    .in_r      (s9_r_r),
    .in_tag    ({s9_n_r, s9_neg_r, s9_nz_r, s9_vel_r}),
    .out_valid (x_v),
    .out_e     (x_e),
    .out_tag   (x_tag)
  );

  logic [5:0]         x_n;
  logic               x_neg, x_nz;
  logic signed [34:0] x_vel;
  assign {x_n, x_neg, x_nz, x_vel} = x_tag;

  // ---------------- S10..S12: target speed ----------------
  logic [30:0]        s10_ex;
  logic               s10_v_r, s10_neg_r, s10_nz_r;
  logic [30:0]        s10_om_r;
  logic signed [34:0] s10_vel_r;

  always_comb begin
    if (x_n == 6'd63) begin
      s10_ex = '0;
    end else begin
      s10_ex = x_e >> x_n;
    end
    if (s10_ex > cdpc_pkg::Q30_ONE) begin
      s10_ex = cdpc_pkg::Q30_ONE;
    end
  end

  always_ff @(posedge clk) begin
    s10_om_r  <= cdpc_pkg::Q30_ONE - s10_ex;
    s10_neg_r <= x_neg;
    s10_nz_r  <= x_nz;
    s10_vel_r <= x_vel;
  end

  logic               s11_v_r, s11_neg_r, s11_nz_r;
  logic [61:0]        s11_vtm_r;
  logic signed [34:0] s11_vel_r;

  always_ff @(posedge clk) begin
    s11_vtm_r <= max_speed_r * s10_om_r;
    s11_neg_r <= s10_neg_r;
    s11_nz_r  <= s10_nz_r;
    s11_vel_r <= s10_vel_r;
  end

  logic signed [32:0] s12_vt_nxt, s12_vtu;
  logic               s12_v_r;
  logic signed [32:0] s12_vt_r;
  logic signed [35:0] s12_diff_r;

  assign s12_vtu = $signed({1'b0, s11_vtm_r[61:30]});

  always_comb begin
    if (s11_neg_r) begin
      s12_vt_nxt = -s12_vtu;
    end else if (s11_nz_r) begin
      s12_vt_nxt = s12_vtu;
    end else begin
      s12_vt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    s12_vt_r   <= s12_vt_nxt;
    s12_diff_r <= 36'(s12_vt_nxt) - 36'(s11_vel_r);
  end

  // ---------------- S13..S15: gains, sum and clamp ----------------
  logic [35:0] s13_m1;
  logic [32:0] s13_m2;
  logic        s13_v_r, s13_n1_r, s13_n2_r;
  logic [49:0] s13_a1_r;
  logic [46:0] s13_b1_r, s13_a2_r, s13_b2_r;

  assign s13_m1 = s12_diff_r[35] ? 36'(-s12_diff_r) : 36'(s12_diff_r);
  assign s13_m2 = s12_vt_r[32] ? 33'(-s12_vt_r) : 33'(s12_vt_r);

  always_ff @(posedge clk) begin
    s13_a1_r <= s13_m1[34:16] * speed_gain_r;
    s13_b1_r <= s13_m1[15:0] * speed_gain_r;
    s13_a2_r <= s13_m2[31:16] * ff_gain_r;
    s13_b2_r <= s13_m2[15:0] * ff_gain_r;
    s13_n1_r <= s12_diff_r[35];
    s13_n2_r <= s12_vt_r[32];
  end

  logic [50:0]        s14_g1;
  logic [47:0]        s14_g2;
  logic               s14_v_r;
  logic signed [51:0] s14_g1_r, s14_g2_r;

  // truncation toward zero: magnitudes are cut, then the sign applied
  assign s14_g1 = 51'(s13_a1_r) + 51'(s13_b1_r >> 16);
  assign s14_g2 = 48'(s13_a2_r) + 48'(s13_b2_r >> 16);

  always_ff @(posedge clk) begin
    s14_g1_r <= s13_n1_r ? -$signed({1'b0, s14_g1}) : $signed({1'b0, s14_g1});
    s14_g2_r <= s13_n2_r ? -$signed({4'b0, s14_g2}) : $signed({4'b0, s14_g2});
  end

  logic signed [52:0] s15_p, s15_lim;
  logic signed [31:0] s15_pwr_nxt;
  logic               out_valid_r;
  logic signed [31:0] out_power_r;

  assign s15_p   = 53'(s14_g1_r) + 53'(s14_g2_r);
  assign s15_lim = $signed({22'b0, power_limit_r});

  always_comb begin
    if (s15_p > s15_lim) begin
      s15_pwr_nxt = 32'(s15_lim);
    end else if (s15_p < -s15_lim) begin
      s15_pwr_nxt = 32'(-s15_lim);
    end else begin
      s15_pwr_nxt = 32'(s15_p);
    end
  end

  always_ff @(posedge clk) begin
    out_power_r <= s15_pwr_nxt;
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      s7_v_r      <= 1'b0;
      s8_v_r      <= 1'b0;
      s9_v_r      <= 1'b0;
      s10_v_r     <= 1'b0;
      s11_v_r     <= 1'b0;
      s12_v_r     <= 1'b0;
      s13_v_r     <= 1'b0;
      s14_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_v_r      <= start && !busy;
      s1_v_r      <= c1_v && h_v;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= e_v;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      s6_v_r      <= s5_v_r;
      s7_v_r      <= s6_v_r;
      s8_v_r      <= s7_v_r;
      s9_v_r      <= s8_v_r;
      s10_v_r     <= x_v;
      s11_v_r     <= s10_v_r;
      s12_v_r     <= s11_v_r;
      s13_v_r     <= s12_v_r;
      s14_v_r     <= s13_v_r;
      out_valid_r <= s14_v_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_power  = out_power_r;
  assign out_right_power = out_power_r;

endmodule

// ===== sv/cdpc_checker.sv =====
// cdpc_checker: port-level assertions for cascaded_drive_power_controller,
// bound to the top level below. Uses cdpc_pkg.
module cdpc_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_left_power,
  input logic [31:0] out_right_power,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic        pready
);

  localparam int LAT = 2 * CORDIC_STEPS + 54;

  // shadow of the power limit as written on the bus
  logic [30:0]        lim_r;
  logic signed [32:0] pwr, lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= '0;
    end else if (psel && penable && pwrite && pready &&
                 cdpc_pkg::cfg_reg_t'(paddr[4:2]) == cdpc_pkg::REG_POWER_LIMIT) begin
      lim_r <= pwdata[30:0];
    end
  end

  assign pwr = 33'($signed(out_left_power));
  assign lim = $signed({2'b0, lim_r});

  a_sides_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left_power == out_right_power)
    else $error("left and right power differ");

  a_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pwr <= lim) && (pwr >= -lim))
    else $error("power outside limit");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe straight after reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an item accepted at the pipeline latency");

endmodule

bind cascaded_drive_power_controller cdpc_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_cdpc_checker (.*);
